// ----- design/saj_pkg.sv -----
package saj_pkg;

  // Angle range and reset positions
  localparam logic [7:0] ANGLE_MAX       = 8'd180;
  localparam logic [7:0] ANGLE_ONE_RST   = 8'd0;
  localparam logic [7:0] ANGLE_TWO_RST   = 8'd110;
  localparam logic [7:0] ANGLE_THREE_RST = 8'd145;

  // Configuration register defaults
  localparam logic [7:0]  STEP_RST  = 8'd5;
  localparam logic [15:0] RAMP_RST  = 16'd20;
  localparam logic [15:0] PAUSE_RST = 16'd200;

  // Command characters
  localparam logic [7:0] KEY_ONE_UP    = 8'h51; // Q
  localparam logic [7:0] KEY_ONE_DN    = 8'h41; // A
  localparam logic [7:0] KEY_TWO_UP    = 8'h57; // W
  localparam logic [7:0] KEY_TWO_DN    = 8'h58; // X
  localparam logic [7:0] KEY_THREE_UP  = 8'h45; // E
  localparam logic [7:0] KEY_THREE_DN  = 8'h44; // D
  localparam logic [7:0] KEY_TAKE      = 8'h5A; // Z
  localparam logic [7:0] KEY_THROW     = 8'h4E; // N

  // Item kinds
  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP  = 2'd0;
  localparam logic [1:0] CFG_RAMP  = 2'd1;
  localparam logic [1:0] CFG_PAUSE = 2'd2;

  // Servo indexes and move numbers
  localparam logic [1:0] SERVO_ONE   = 2'd0;
  localparam logic [1:0] SERVO_TWO   = 2'd1;
  localparam logic [1:0] SERVO_THREE = 2'd2;
  localparam logic [1:0] MOVE_FIRST  = 2'd0;
  localparam logic [1:0] MOVE_SECOND = 2'd1;
  localparam logic [1:0] MOVE_LAST   = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_TAKE  = 3'b010,
    SEQ_THROW = 3'b100
  } seq_t;

  // Servo driven by a given move of a sequence
  function automatic logic [1:0] seq_servo(input logic throw, input logic [1:0] mi);
    logic [1:0] s;
    case (mi)
      MOVE_FIRST:  s = throw ? SERVO_TWO : SERVO_THREE;
      MOVE_SECOND: s = throw ? SERVO_ONE : SERVO_TWO;
      default:     s = SERVO_THREE;
    endcase
    return s;
  endfunction

  // Target angle of a given move of a sequence
  function automatic logic [7:0] seq_target(input logic throw, input logic [1:0] mi);
    logic [7:0] t;
    case (mi)
      MOVE_FIRST:  t = throw ? 8'd145 : 8'd80;
      MOVE_SECOND: t = throw ? 8'd180 : 8'd85;
      default:     t = throw ? 8'd180 : 8'd125;
    endcase
    return t;
  endfunction

endpackage

// ----- design/servo_arm_jog_and_sequence.sv -----
// A request passes through the input register and then the result register.
// Throughput: one request per cycle while out_stall is low; the whole update of angles and
// sequence state is one short combinational pass between the input and result registers.
// Reset: synchronous, active low; angles go to 0, 110 and 145, sequence idle, counters zero,
// configuration back to step 5, ramp 20 and pause 200 ticks, both stages empty.
module servo_arm_jog_and_sequence (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_key_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_angle_one,
  output logic [7:0]  out_angle_two,
  output logic [7:0]  out_angle_three,
  output logic        out_busy_res,
  output logic        out_dropped
);
  import saj_pkg::*;

  // Configuration registers
  logic [7:0]  step_r;
  logic [15:0] ramp_r;
  logic [15:0] pause_r;

  // Input stage
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_key_r;

  // Arm state
  logic [7:0]  angle_r [3];
  logic [7:0]  angle_nxt [3];
  seq_t        seq_r, seq_nxt;
  logic [1:0]  move_r, move_nxt;
  logic        pause_flag_r, pause_flag_nxt;
  logic [15:0] count_r, count_nxt;
  logic        dropped_nxt;

  // Result stage
  logic       out_valid_r;
  logic [7:0] out_one_r, out_two_r, out_three_r;
  logic       out_busy_r, out_dropped_r;

  logic s2_ready, s1_ready, advance;

  // Handshake: result register frees when empty or taken
  assign s2_ready = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign advance  = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_RST;
      ramp_r  <= RAMP_RST;
      pause_r <= PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP:  step_r  <= cfg_wdata[7:0];
        CFG_RAMP:  ramp_r  <= cfg_wdata;
        CFG_PAUSE: pause_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_cmd_r <= in_cmd;
      s1_key_r <= in_key_code;
    end
  end

  // Compute the next arm state for the held request
  always_comb begin
    logic        throw_sel;
    logic [1:0]  mi;
    logic [1:0]  idx;
    logic [7:0]  tgt;
    logic [7:0]  cur;
    logic [15:0] cnt_inc;
    logic        jog_en;
    logic        jog_up;
    logic [1:0]  jog_idx;
    logic [8:0]  up_sum;
    logic [7:0]  jog_val;

    angle_nxt      = angle_r;
    seq_nxt        = seq_r;
    move_nxt       = move_r;
    pause_flag_nxt = pause_flag_r;
    count_nxt      = count_r;
    dropped_nxt    = 1'b0;

    throw_sel = (seq_r == SEQ_THROW);
    mi        = (move_r > MOVE_LAST) ? MOVE_FIRST : move_r;
    idx       = seq_servo(throw_sel, mi);
    tgt       = seq_target(throw_sel, mi);
    cur       = angle_r[idx];
    cnt_inc   = (count_r == 16'hFFFF) ? count_r : count_r + 16'd1;

    jog_en  = 1'b0;
    jog_up  = 1'b0;
    jog_idx = SERVO_ONE;
    up_sum  = 9'd0;
    jog_val = 8'd0;

    if (s1_cmd_r == CMD_TICK) begin
      if (seq_r != SEQ_TAKE && seq_r != SEQ_THROW) begin
        seq_nxt = SEQ_IDLE;
      end else if (pause_flag_r) begin
        // Count the pause, then advance to the next move or finish
        count_nxt = cnt_inc;
        if (cnt_inc >= pause_r) begin
          count_nxt      = 16'd0;
          pause_flag_nxt = 1'b0;
          if (mi == MOVE_LAST) begin
            seq_nxt  = SEQ_IDLE;
            move_nxt = MOVE_FIRST;
          end else begin
            move_nxt = mi + 2'd1;
          end
        end
      end else begin
        // Ramp the active servo one degree per ramp period
        if (cur != tgt) begin
          count_nxt = cnt_inc;
          if (cnt_inc >= ramp_r) begin
            count_nxt = 16'd0;
            cur       = (cur < tgt) ? cur + 8'd1 : cur - 8'd1;
            angle_nxt[idx] = cur;
          end
        end
        if (cur == tgt) begin
          pause_flag_nxt = 1'b1;
          count_nxt      = 16'd0;
        end
      end
    end else if (seq_r != SEQ_IDLE) begin
      dropped_nxt = 1'b1;
    end else begin
      // Decode the command character
      unique case (s1_key_r)
        KEY_ONE_UP:   begin jog_en = 1'b1; jog_up = 1'b1; jog_idx = SERVO_ONE;   end
        KEY_ONE_DN:   begin jog_en = 1'b1; jog_up = 1'b0; jog_idx = SERVO_ONE;   end
        KEY_TWO_UP:   begin jog_en = 1'b1; jog_up = 1'b1; jog_idx = SERVO_TWO;   end
        KEY_TWO_DN:   begin jog_en = 1'b1; jog_up = 1'b0; jog_idx = SERVO_TWO;   end
        KEY_THREE_UP: begin jog_en = 1'b1; jog_up = 1'b1; jog_idx = SERVO_THREE; end
        KEY_THREE_DN: begin jog_en = 1'b1; jog_up = 1'b0; jog_idx = SERVO_THREE; end
        KEY_TAKE, KEY_THROW: begin
          seq_nxt        = (s1_key_r == KEY_TAKE) ? SEQ_TAKE : SEQ_THROW;
          move_nxt       = MOVE_FIRST;
          pause_flag_nxt = 1'b0;
          count_nxt      = 16'd0;
        end
        default: ;
      endcase
      // Jog with saturation at both ends
      if (jog_en) begin
        up_sum = {1'b0, angle_r[jog_idx]} + {1'b0, step_r};
        if (jog_up) begin
          jog_val = (up_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : up_sum[7:0];
        end else begin
          jog_val = (angle_r[jog_idx] > step_r) ? angle_r[jog_idx] - step_r : 8'd0;
        end
        angle_nxt[jog_idx] = jog_val;
      end
    end
  end

  // Update arm state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r[0]   <= ANGLE_ONE_RST;
      angle_r[1]   <= ANGLE_TWO_RST;
      angle_r[2]   <= ANGLE_THREE_RST;
      seq_r        <= SEQ_IDLE;
      move_r       <= MOVE_FIRST;
      pause_flag_r <= 1'b0;
      count_r      <= 16'd0;
    end else if (advance) begin
      angle_r      <= angle_nxt;
      seq_r        <= seq_nxt;
      move_r       <= move_nxt;
      pause_flag_r <= pause_flag_nxt;
      count_r      <= count_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_one_r     <= angle_nxt[0];
      out_two_r     <= angle_nxt[1];
      out_three_r   <= angle_nxt[2];
      out_busy_r    <= (seq_nxt != SEQ_IDLE);
      out_dropped_r <= dropped_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_angle_one   = out_one_r;
  assign out_angle_two   = out_two_r;
  assign out_angle_three = out_three_r;
  assign out_busy_res    = out_busy_r;
  assign out_dropped     = out_dropped_r;

  // A dropped request leaves the sequence running
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_r |-> out_busy_r)
    else $error("dropped request reported while idle");

  // Angles stay in range
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    angle_r[0] <= ANGLE_MAX && angle_r[1] <= ANGLE_MAX && angle_r[2] <= ANGLE_MAX)
    else $error("servo angle out of range");

  // Idle implies a clean sequence state
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SEQ_IDLE |-> move_r == MOVE_FIRST && !pause_flag_r)
    else $error("idle with leftover move state");

  // Move number never leaves the three moves
  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    move_r <= MOVE_LAST)
    else $error("move index out of range");

  // A stalled result keeps the held request stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_cmd_r))
    else $error("held request lost under stall");

endmodule

// ----- sim/servo_arm_jog_and_sequence_tb.sv -----
`timescale 1ns / 1ps

module servo_arm_jog_and_sequence_tb;
  import saj_pkg::*;

  // Sequence targets other than the top of the range
  localparam logic [7:0] TAKE_LOWER = 8'd80;
  localparam logic [7:0] TAKE_GRIP  = 8'd85;
  localparam logic [7:0] TAKE_RAISE = 8'd125;
  localparam logic [7:0] THROW_WIND = 8'd145;

  // Byte that must not match the jog key for servo one (lower case q)
  localparam logic [7:0] KEY_ONE_UP_LOWER = 8'h71;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_AFTER  = 500;
  localparam int HOLD_CYCLES = 100;

  typedef struct packed {
    logic [7:0] one;
    logic [7:0] two;
    logic [7:0] three;
    logic       busy;
    logic       dropped;
  } arm_result_t;

  // Tracks the commanded angles and sequence state, and holds the results
  // still owed by the block
  class arm_motion_model;
    logic [7:0]  step_deg;
    logic [15:0] ramp_len;
    logic [15:0] pause_len;
    logic [7:0]  angle [3];
    seq_t        routine;
    logic [1:0]  move;
    bit          pausing;
    logic [15:0] count;
    arm_result_t expected_angles [$];
    int          mismatches;

    function new();
      step_deg   = STEP_RST;
      ramp_len   = RAMP_RST;
      pause_len  = PAUSE_RST;
      angle[0]   = ANGLE_ONE_RST;
      angle[1]   = ANGLE_TWO_RST;
      angle[2]   = ANGLE_THREE_RST;
      routine    = SEQ_IDLE;
      move       = MOVE_FIRST;
      pausing    = 1'b0;
      count      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_STEP:  step_deg  = data[7:0];
        CFG_RAMP:  ramp_len  = data;
        CFG_PAUSE: pause_len = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_angles.size();
    endfunction

    function bit is_busy();
      return routine != SEQ_IDLE;
    endfunction

    function void jog(logic [1:0] servo, bit up);
      int a;
      int s;
      a = angle[servo];
      s = step_deg;
      if (up) begin
        a = a + s;
        if (a > ANGLE_MAX) a = ANGLE_MAX;
      end else begin
        a = (a > s) ? a - s : 0;
      end
      angle[servo] = a[7:0];
    endfunction

    // Servo and target of the move in progress
    function void current_move(output logic [1:0] servo, output logic [7:0] target);
      case ({routine == SEQ_THROW, move})
        {1'b0, MOVE_FIRST}:  begin servo = SERVO_THREE; target = TAKE_LOWER; end
        {1'b0, MOVE_SECOND}: begin servo = SERVO_TWO;   target = TAKE_GRIP;  end
        {1'b1, MOVE_FIRST}:  begin servo = SERVO_TWO;   target = THROW_WIND; end
        {1'b1, MOVE_SECOND}: begin servo = SERVO_ONE;   target = ANGLE_MAX;  end
        {1'b1, MOVE_LAST}:   begin servo = SERVO_THREE; target = ANGLE_MAX;  end
        default:             begin servo = SERVO_THREE; target = TAKE_RAISE; end
      endcase
    endfunction

    // Advance the running sequence by one tick
    function void advance_tick();
      logic [1:0] servo;
      logic [7:0] target;
      if (routine == SEQ_IDLE) return;
      if (pausing) begin
        if (count != 16'hFFFF) count++;
        if (count >= pause_len) begin
          count   = '0;
          pausing = 1'b0;
          if (move == MOVE_LAST) begin
            routine = SEQ_IDLE;
            move    = MOVE_FIRST;
          end else begin
            move = move + 2'd1;
          end
        end
        return;
      end
      current_move(servo, target);
      if (angle[servo] != target) begin
        if (count != 16'hFFFF) count++;
        if (count >= ramp_len) begin
          count = '0;
          if (angle[servo] < target) angle[servo]++;
          else angle[servo]--;
        end
      end
      if (angle[servo] == target) begin
        pausing = 1'b1;
        count   = '0;
      end
    endfunction

    function void begin_sequence(seq_t which);
      routine = which;
      move    = MOVE_FIRST;
      pausing = 1'b0;
      count   = '0;
    endfunction

    // Apply one accepted request and queue the result it owes
    function void note_request(logic c, logic [7:0] k);
      arm_result_t r;
      r.dropped = 1'b0;
      if (c == CMD_TICK) begin
        advance_tick();
      end else if (routine != SEQ_IDLE) begin
        r.dropped = 1'b1;
      end else begin
        case (k)
          KEY_ONE_UP:   jog(SERVO_ONE, 1'b1);
          KEY_ONE_DN:   jog(SERVO_ONE, 1'b0);
          KEY_TWO_UP:   jog(SERVO_TWO, 1'b1);
          KEY_TWO_DN:   jog(SERVO_TWO, 1'b0);
          KEY_THREE_UP: jog(SERVO_THREE, 1'b1);
          KEY_THREE_DN: jog(SERVO_THREE, 1'b0);
          KEY_TAKE:     begin_sequence(SEQ_TAKE);
          KEY_THROW:    begin_sequence(SEQ_THROW);
          default: ;
        endcase
      end
      r.one   = angle[0];
      r.two   = angle[1];
      r.three = angle[2];
      r.busy  = (routine != SEQ_IDLE);
      expected_angles.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(arm_result_t got);
      arm_result_t want;
      if (expected_angles.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_angles.pop_front();
      compare_field("angle_one", want.one, got.one);
      compare_field("angle_two", want.two, got.two);
      compare_field("angle_three", want.three, got.three);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("dropped", want.dropped, got.dropped);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_key_code;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_angle_one;
  logic [7:0]  out_angle_two;
  logic [7:0]  out_angle_three;
  logic        out_busy_res;
  logic        out_dropped;

  arm_motion_model motion = new();
  int sent;
  int results_seen;
  logic [7:0] jog_keys [6] = '{KEY_ONE_UP, KEY_ONE_DN, KEY_TWO_UP,
                               KEY_TWO_DN, KEY_THREE_UP, KEY_THREE_DN};

  servo_arm_jog_and_sequence uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_key_code     (in_key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_one   (out_angle_one),
    .out_angle_two   (out_angle_two),
    .out_angle_three (out_angle_three),
    .out_busy_res    (out_busy_res),
    .out_dropped     (out_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic send_request(logic c, logic [7:0] k);
    int gap;
    gap = ((sent / 40) % 4 == 0) ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_cmd      <= c;
    in_key_code <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    motion.note_request(c, k);
    sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait until every result owed has come back, then let the pipe empty
  task automatic settle();
    while (motion.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    motion.set_reg(idx, data);
  endtask

  // Mostly ticks while a sequence runs; jogs and sequence starts while idle
  task automatic make_request(output logic c, output logic [7:0] k);
    int roll;
    roll = $urandom_range(0, 99);
    k    = 8'($urandom_range(0, 255));
    if (motion.is_busy()) begin
      c = (roll < 88) ? CMD_TICK : CMD_KEY;
    end else if (roll < 30) begin
      c = CMD_TICK;
    end else begin
      c = CMD_KEY;
      if (roll < 62) k = jog_keys[$urandom_range(0, 5)];
      else if (roll < 82) k = (roll % 2 == 0) ? KEY_TAKE : KEY_THROW;
    end
  endtask

  task automatic run_phase(logic [7:0] step, logic [15:0] ramp, logic [15:0] pause,
                           int count);
    logic       c;
    logic [7:0] k;
    settle();
    // upper byte of the step write must be ignored
    write_reg(CFG_STEP, {8'($urandom_range(0, 255)), step});
    write_reg(CFG_RAMP, ramp);
    write_reg(CFG_PAUSE, pause);
    repeat (count) begin
      make_request(c, k);
      send_request(c, k);
    end
    drop_valid();
  endtask

  initial begin : stimulus
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_STEP;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_cmd      = CMD_KEY;
    in_key_code = '0;
    sent        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, jog limits, unknown keys, command while busy
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_KEY, KEY_ONE_DN);
    send_request(CMD_KEY, KEY_ONE_UP);
    send_request(CMD_KEY, KEY_ONE_UP);
    send_request(CMD_KEY, KEY_TWO_UP);
    send_request(CMD_KEY, KEY_TWO_DN);
    repeat (8) send_request(CMD_KEY, KEY_THREE_UP);
    send_request(CMD_KEY, KEY_THREE_DN);
    send_request(CMD_KEY, KEY_ONE_UP_LOWER);
    send_request(CMD_KEY, 8'h00);
    send_request(CMD_KEY, 8'hFF);
    send_request(CMD_KEY, KEY_TAKE);
    send_request(CMD_KEY, KEY_THROW);
    send_request(CMD_TICK, 8'h00);
    drop_valid();

    // Extremes of the settings, then random ones
    run_phase(8'd0, 16'd1, 16'd0, 200);
    run_phase(8'd180, 16'd0, 16'd1, 220);
    run_phase(8'd255, 16'd2, 16'd3, 220);
    run_phase(8'd1, 16'hFFFF, 16'd5, 110);
    run_phase(8'd7, 16'd1, 16'hFFFF, 110);
    repeat (6) run_phase(8'($urandom_range(0, 200)), 16'($urandom_range(0, 2)),
                         16'($urandom_range(0, 12)), 165);

    settle();
    repeat (6) @(posedge clk);
    if (motion.mismatches == 0 && motion.pending() == 0) begin
      $display("servo_arm_jog_and_sequence_tb: clean");
    end else begin
      $display("servo_arm_jog_and_sequence_tb: errors");
    end
    $finish;
  end

  // Take results after random stalls; hold off once long enough to back up the input
  initial begin : result_side
    int gap;
    arm_result_t got;
    out_stall    = 1'b0;
    results_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == HOLD_AFTER) gap = HOLD_CYCLES;
      else if ((results_seen / 60) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 14);
      repeat (gap) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.one     = out_angle_one;
      got.two     = out_angle_two;
      got.three   = out_angle_three;
      got.busy    = out_busy_res;
      got.dropped = out_dropped;
      motion.check_result(got);
      results_seen++;
    end
  end

  // End the run if nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    wait (rst_n === 1'b1);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle = 0;
      else idle++;
    end
    $display("servo_arm_jog_and_sequence_tb: errors");
    $finish;
  end

endmodule
